/* src/pcs_pkg.sv */
package pcs_pkg;

    // Fraction bits of the offsets (Q.8)
    localparam int OFF_FRAC  = 8;
    localparam int GAIN_BITS = 24;
    localparam int CUR_BITS  = 32;
    // Q.32 product down to Q.16 current
    localparam int CUR_SHIFT = 16;

    // 3.3 / 4096 / (0.005 * 40) in Q0.24
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 24'd67584;

    typedef enum logic [1:0] {
        OP_CONVERT    = 2'd0,
        OP_CAL_ACC    = 2'd1,
        OP_CAL_FINISH = 2'd2
    } opcode_t;

    typedef struct packed {
        logic acc;
        logic phase_b;
        logic finish;
    } cal_cmd_t;

endpackage

/* src/pcs_if.sv */
interface pcs_in_if #(
    parameter int ADC_BITS = 12
);
    logic                valid;
    logic                ready;
    logic [1:0]          opcode;
    logic                phase_select;
    logic [ADC_BITS-1:0] adc_sample;

    modport source (output valid, output opcode, output phase_select, output adc_sample,
                    input ready);
    modport sink   (input valid, input opcode, input phase_select, input adc_sample,
                    output ready);
endinterface

interface pcs_out_if import pcs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [CUR_BITS-1:0] current_a;
    logic signed [CUR_BITS-1:0] current_b;
    logic signed [CUR_BITS-1:0] current_c;

    modport source (output valid, output current_a, output current_b, output current_c,
                    input ready);
    modport sink   (input valid, input current_a, input current_b, input current_c,
                    output ready);
endinterface

interface pcs_cfg_if import pcs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [GAIN_BITS-1:0] amps_per_lsb;

    modport source (output valid, output amps_per_lsb, input ready);
    modport sink   (input valid, input amps_per_lsb, output ready);
endinterface

/* src/pcs_offset_cal.sv */
module pcs_offset_cal
    import pcs_pkg::*;
#(
    parameter int ADC_BITS       = 12,
    parameter int CAL_COUNT_LOG2 = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cal_cmd_t                     cmd,
    input  logic [ADC_BITS-1:0]          sample,
    output logic [ADC_BITS+OFF_FRAC-1:0] offset_a,
    output logic [ADC_BITS+OFF_FRAC-1:0] offset_b
);

    localparam int OFF_W = ADC_BITS + OFF_FRAC;
    localparam int SUM_W = ADC_BITS + CAL_COUNT_LOG2;
    localparam logic [OFF_W-1:0] OFFSET_RESET = {1'b1, {(OFF_W-1){1'b0}}};

    logic [SUM_W-1:0] sum_a_reg, sum_a_next;
    logic [SUM_W-1:0] sum_b_reg, sum_b_next;
    logic [OFF_W-1:0] off_a_reg, off_a_next;
    logic [OFF_W-1:0] off_b_reg, off_b_next;

    logic [SUM_W:0]          acc_sum;
    logic [SUM_W-1:0]        acc_sat;
    logic [SUM_W+OFF_FRAC-1:0] mean_a_wide, mean_b_wide;

    // carry out of the add means the sum passed its all-ones limit
    assign acc_sum = {1'b0, (cmd.phase_b ? sum_b_reg : sum_a_reg)}
                   + {{(CAL_COUNT_LOG2+1){1'b0}}, sample};
    assign acc_sat = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];

    // mean in Q.8: (sum << 8) >> log2(count)
    assign mean_a_wide = {sum_a_reg, {OFF_FRAC{1'b0}}};
    assign mean_b_wide = {sum_b_reg, {OFF_FRAC{1'b0}}};

    always_comb
    begin
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        off_a_next = off_a_reg;
        off_b_next = off_b_reg;
        if (cmd.finish)
        begin
            off_a_next = mean_a_wide[SUM_W+OFF_FRAC-1:CAL_COUNT_LOG2];
            off_b_next = mean_b_wide[SUM_W+OFF_FRAC-1:CAL_COUNT_LOG2];
            sum_a_next = '0;
            sum_b_next = '0;
        end
        else if (cmd.acc)
        begin
            if (cmd.phase_b)
            begin
                sum_b_next = acc_sat;
            end
            else
            begin
                sum_a_next = acc_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            off_a_reg <= OFFSET_RESET;
            off_b_reg <= OFFSET_RESET;
        end
        else
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            off_a_reg <= off_a_next;
            off_b_reg <= off_b_next;
        end
    end

    assign offset_a = off_a_reg;
    assign offset_b = off_b_reg;

endmodule

/* src/pcs_product.sv */
module pcs_product
    import pcs_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  logic                                  advance,
    input  logic                                  phase_b,
    input  logic [ADC_BITS-1:0]                   sample,
    input  logic [ADC_BITS+OFF_FRAC-1:0]          offset,
    input  logic [GAIN_BITS-1:0]                  gain,
    output logic                                  valid,
    output logic                                  prod_phase_b,
    output logic signed [ADC_BITS+OFF_FRAC+GAIN_BITS+1:0] prod
);

    localparam int DIFF_W = ADC_BITS + OFF_FRAC + 1;
    localparam int PROD_W = DIFF_W + GAIN_BITS + 1;

    logic                     valid_reg, valid_next;
    logic                     phase_b_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] diff_ext, gain_ext, prod_next;

    // (sample << 8) - offset, Q.8 signed
    assign diff      = $signed({1'b0, sample, {OFF_FRAC{1'b0}}}) - $signed({1'b0, offset});
    assign diff_ext  = {{(GAIN_BITS+1){diff[DIFF_W-1]}}, diff};
    assign gain_ext  = $signed({{(DIFF_W+1){1'b0}}, gain});
    assign prod_next = diff_ext * gain_ext;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg    <= prod_next;
            phase_b_reg <= phase_b;
        end
    end

    assign valid        = valid_reg;
    assign prod_phase_b = phase_b_reg;
    assign prod         = prod_reg;

endmodule

/* src/pcs_combine.sv */
module pcs_combine
    import pcs_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          step,
    input  logic                                          phase_b,
    input  logic signed [ADC_BITS+OFF_FRAC+GAIN_BITS+1:0] prod,
    pcs_out_if.source                                     currents
);

    localparam int PROD_W = ADC_BITS + OFF_FRAC + GAIN_BITS + 2;
    localparam int SH_W   = PROD_W - CUR_SHIFT;
    localparam int EXT_W  = SH_W + CUR_BITS + 1;
    localparam logic signed [CUR_BITS-1:0] CUR_MAX = {1'b0, {(CUR_BITS-1){1'b1}}};
    localparam logic signed [CUR_BITS-1:0] CUR_MIN = {1'b1, {(CUR_BITS-1){1'b0}}};

    logic                       out_valid_reg, out_valid_next;
    logic signed [CUR_BITS-1:0] held_a_reg, held_a_next;
    logic signed [CUR_BITS-1:0] cur_a_reg, cur_b_reg, cur_c_reg;

    logic signed [SH_W-1:0]     shifted;
    logic signed [EXT_W-1:0]    ext;
    logic [EXT_W-CUR_BITS:0]    ext_top;
    logic signed [CUR_BITS-1:0] cur;
    logic signed [CUR_BITS+1:0] c_wide;
    logic signed [CUR_BITS-1:0] cur_c;

    // dropping the low bits of a signed word is a floor shift
    assign shifted = prod[PROD_W-1:CUR_SHIFT];
    assign ext     = {{(CUR_BITS+1){shifted[SH_W-1]}}, shifted};
    assign ext_top = ext[EXT_W-1:CUR_BITS-1];

    always_comb
    begin
        if ((&ext_top) || !(|ext_top))
        begin
            cur = ext[CUR_BITS-1:0];
        end
        else
        begin
            cur = ext[EXT_W-1] ? CUR_MIN : CUR_MAX;
        end
    end

    // phase C = -A - B, saturated
    assign c_wide = -$signed({{2{held_a_reg[CUR_BITS-1]}}, held_a_reg})
                    - $signed({{2{cur[CUR_BITS-1]}}, cur});

    always_comb
    begin
        if ((&c_wide[CUR_BITS+1:CUR_BITS-1]) || !(|c_wide[CUR_BITS+1:CUR_BITS-1]))
        begin
            cur_c = c_wide[CUR_BITS-1:0];
        end
        else
        begin
            cur_c = c_wide[CUR_BITS+1] ? CUR_MIN : CUR_MAX;
        end
    end

    always_comb
    begin
        held_a_next    = held_a_reg;
        out_valid_next = out_valid_reg;
        if (currents.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (step)
        begin
            if (phase_b)
            begin
                out_valid_next = 1'b1;
            end
            else
            begin
                held_a_next = cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_a_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            held_a_reg    <= held_a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && phase_b)
        begin
            cur_a_reg <= held_a_reg;
            cur_b_reg <= cur;
            cur_c_reg <= cur_c;
        end
    end

    assign currents.valid     = out_valid_reg;
    assign currents.current_a = cur_a_reg;
    assign currents.current_b = cur_b_reg;
    assign currents.current_c = cur_c_reg;

endmodule

/* src/phase_current_sense_with_offset_cal_top.sv */
// Two-shunt phase current sensing with converter offset calibration.
//
// samples  : request = opcode, phase_select, adc_sample. Convert (phase A)
//            only updates the held phase-A current; convert (phase B)
//            produces one request on currents. Calibrate adds the sample to
//            that phase's saturating sum; finish loads both offsets with
//            sum / 2^CAL_COUNT_LOG2 in Q.8 and clears the sums.
// currents : request = current_a, current_b, current_c (signed Q.16 A),
//            current_c = -A - B, all saturated to 32 bits.
// cfg      : amps_per_lsb gain, Q0.24. Always ready; write only while idle.
//
// Path: a phase-B convert passes the input, product and output registers
// in order before it shows on currents. Throughput: one request per cycle
// unless the output stalls, set by the single gain multiply in the product
// stage. Each stage moves when the next one is free, so a stalled output
// register keeps one result while the stages behind it still fill;
// calibrate and phase-A items keep flowing while a result waits, until
// a phase-B convert holds the product stage. Reset: offsets 2048.0, sums
// and held current zero, gain 67584, no request pending on any channel.
module phase_current_sense_with_offset_cal_top
    import pcs_pkg::*;
#(
    parameter int ADC_BITS       = 12,
    parameter int CAL_COUNT_LOG2 = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    pcs_in_if.sink    samples,
    pcs_out_if.source currents,
    pcs_cfg_if.sink   cfg
);

    localparam int OFF_W  = ADC_BITS + OFF_FRAC;
    localparam int PROD_W = OFF_W + GAIN_BITS + 2;

    logic [GAIN_BITS-1:0] gain_reg;

    // input register
    logic                s1_valid_reg, s1_valid_next;
    logic [1:0]          s1_op_reg;
    logic                s1_phase_reg;
    logic [ADC_BITS-1:0] s1_sample_reg;

    logic     s1_convert;
    logic     s1_adv;
    logic     s2_valid, s2_phase_b, s2_adv, s2_free;
    logic     out_free;
    cal_cmd_t cal_cmd;
    logic [OFF_W-1:0] offset_a, offset_b;
    logic signed [PROD_W-1:0] prod;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            gain_reg <= cfg.amps_per_lsb;
        end
    end

    // decode of the request in the input register
    always_comb
    begin
        s1_convert      = 1'b0;
        cal_cmd.acc     = 1'b0;
        cal_cmd.finish  = 1'b0;
        cal_cmd.phase_b = s1_phase_reg;
        unique case (opcode_t'(s1_op_reg))
            OP_CONVERT:    s1_convert     = 1'b1;
            OP_CAL_ACC:    cal_cmd.acc    = s1_valid_reg;
            OP_CAL_FINISH: cal_cmd.finish = s1_valid_reg;
            default:       s1_convert     = 1'b0;
        endcase
    end

    // flow control: out register <- product register <- input register
    assign out_free = !currents.valid || currents.ready;
    assign s2_adv   = s2_valid && (!s2_phase_b || out_free);
    assign s2_free  = !s2_valid || s2_adv;
    // only converts need the product stage; calibration retires here
    assign s1_adv   = s1_valid_reg && (!s1_convert || s2_free);
    assign samples.ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (samples.valid && samples.ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_op_reg     <= samples.opcode;
            s1_phase_reg  <= samples.phase_select;
            s1_sample_reg <= samples.adc_sample;
        end
    end

    pcs_offset_cal #(
        .ADC_BITS       (ADC_BITS),
        .CAL_COUNT_LOG2 (CAL_COUNT_LOG2)
    ) u_offset_cal (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cal_cmd),
        .sample   (s1_sample_reg),
        .offset_a (offset_a),
        .offset_b (offset_b)
    );

    pcs_product #(
        .ADC_BITS (ADC_BITS)
    ) u_product (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (s1_adv && s1_convert),
        .advance      (s2_adv),
        .phase_b      (s1_phase_reg),
        .sample       (s1_sample_reg),
        .offset       (s1_phase_reg ? offset_b : offset_a),
        .gain         (gain_reg),
        .valid        (s2_valid),
        .prod_phase_b (s2_phase_b),
        .prod         (prod)
    );

    pcs_combine #(
        .ADC_BITS (ADC_BITS)
    ) u_combine (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (s2_adv),
        .phase_b  (s2_phase_b),
        .prod     (prod),
        .currents (currents)
    );

endmodule
